### rtl/keypad_serial_shift_reader_unit_macros.svh
// ----------------------------------------------------------------------------
// keypad serial shift reader assertion macros
// shared concurrent assertion forms, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SERIAL_SHIFT_READER_UNIT_MACROS_SVH
`define KEYPAD_SERIAL_SHIFT_READER_UNIT_MACROS_SVH

// same-cycle implication
`define KSSR_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("kssr assertion failed");

// next-cycle implication
`define KSSR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("kssr assertion failed");

`endif

### rtl/kssr_pkg.sv
// ----------------------------------------------------------------------------
// kssr package
// shared types and constants of the keypad serial shift reader
// ----------------------------------------------------------------------------
`default_nettype none

package kssr_pkg;

    localparam int unsigned BUTTON_W  = 27;
    localparam int unsigned SERIAL_LEN = 32;
    localparam int unsigned POS_W     = 6;

    // bit places in the button word
    localparam int unsigned BTN_B     = 0;
    localparam int unsigned BTN_UP    = 4;
    localparam int unsigned BTN_DOWN  = 5;
    localparam int unsigned BTN_LEFT  = 6;
    localparam int unsigned BTN_RIGHT = 7;
    localparam int unsigned BTN_END   = 26;

    // signature nibble for serial positions 15..12
    localparam logic [3:0] SIGNATURE = 4'b1101;

    typedef enum logic [0:0] {
        FUNC_LATCH = 1'b0,
        FUNC_READ  = 1'b1
    } t_func;

    typedef struct packed {
        logic [0:0]          func;
        logic                latch_level;
        logic [BUTTON_W-1:0] buttons;
    } t_item;

    typedef struct packed {
        logic  fire;
        t_item item;
    } t_step;

    typedef struct packed {
        logic load;
        logic serial_bit;
    } t_result;

endpackage

`default_nettype wire

### rtl/kssr_if.sv
// ----------------------------------------------------------------------------
// kssr channel interfaces
// valid/ready channels for the request word and the serial result word
// ----------------------------------------------------------------------------
`default_nettype none

interface kssr_in_if;
    logic                          valid;
    logic                          ready;
    logic [0:0]                    func;
    logic                          latch_level;
    logic [kssr_pkg::BUTTON_W-1:0] buttons;

    modport source (output valid, output func, output latch_level, output buttons,
                    input ready);
    modport sink   (input valid, input func, input latch_level, input buttons,
                    output ready);
endinterface

interface kssr_out_if;
    logic valid;
    logic ready;
    logic serial_bit;

    modport source (output valid, output serial_bit, input ready);
    modport sink   (input valid, input serial_bit, output ready);
endinterface

`default_nettype wire

### rtl/kssr_in_reg.sv
// ----------------------------------------------------------------------------
// kssr input register
// holds one accepted request word until the core consumes it
// ----------------------------------------------------------------------------
`default_nettype none

module kssr_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    kssr_in_if.sink              i_in,
    input  wire logic            i_advance,
    output      logic            o_valid,
    output      kssr_pkg::t_item o_item
);

    logic            r_valid;
    kssr_pkg::t_item r_item;
    logic            n_valid;
    logic            w_take;

    assign i_in.ready = !r_valid || i_advance;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.func        <= i_in.func;
            r_item.latch_level <= i_in.latch_level;
            r_item.buttons     <= i_in.buttons;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### rtl/kssr_core.sv
// ----------------------------------------------------------------------------
// kssr core
// latch tracking, button snapshot, direction rule and serial bit select
// ----------------------------------------------------------------------------
`default_nettype none

`include "keypad_serial_shift_reader_unit_macros.svh"

module kssr_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kssr_pkg::t_step   i_step,
    output      kssr_pkg::t_result o_result
);

    logic                                r_latch;
    logic [kssr_pkg::POS_W-1:0]          r_pos;
    logic [kssr_pkg::BUTTON_W-1:0]       r_snap;
    logic                                r_up, r_down, r_left, r_right;
    logic                                r_vhold, r_hhold;

    logic                                n_latch;
    logic [kssr_pkg::POS_W-1:0]          n_pos;
    logic [kssr_pkg::BUTTON_W-1:0]       n_snap;
    logic                                n_up, n_down, n_left, n_right;
    logic                                n_vhold, n_hhold;

    logic                                w_is_read;
    logic                                w_edge;
    logic                                w_up, w_down, w_left, w_right;
    logic [kssr_pkg::SERIAL_LEN-1:0]     w_serial;
    logic                                w_bit;

    assign w_is_read = (i_step.item.func == kssr_pkg::FUNC_READ);
    assign w_edge    = !w_is_read && (i_step.item.latch_level != r_latch);

    assign w_up    = i_step.item.buttons[kssr_pkg::BTN_UP];
    assign w_down  = i_step.item.buttons[kssr_pkg::BTN_DOWN];
    assign w_left  = i_step.item.buttons[kssr_pkg::BTN_LEFT];
    assign w_right = i_step.item.buttons[kssr_pkg::BTN_RIGHT];

    // serial frame, low bit first: snapshot bits, stored directions, snapshot bits, signature, keys, zero, end
    assign w_serial = {r_snap[kssr_pkg::BTN_END], 1'b0, r_snap[25:12],
                       kssr_pkg::SIGNATURE, r_snap[11:8],
                       r_right, r_left, r_down, r_up, r_snap[3:0]};

    always_comb begin
        if (r_latch) begin
            w_bit = i_step.item.buttons[kssr_pkg::BTN_B];
        end else if (r_pos[kssr_pkg::POS_W-1]) begin
            w_bit = 1'b1;
        end else begin
            w_bit = w_serial[r_pos[kssr_pkg::POS_W-2:0]];
        end
    end

    always_comb begin
        n_latch = r_latch;
        n_pos   = r_pos;
        n_snap  = r_snap;
        n_up    = r_up;
        n_down  = r_down;
        n_left  = r_left;
        n_right = r_right;
        n_vhold = r_vhold;
        n_hhold = r_hhold;
        if (i_step.fire) begin
            if (w_edge) begin
                n_latch = i_step.item.latch_level;
                n_pos   = '0;
                if (!i_step.item.latch_level) begin
                    n_snap = i_step.item.buttons;
                    if (!(w_up && w_down)) begin
                        n_vhold = 1'b0;
                        n_up    = w_up;
                        n_down  = w_down;
                    end else if (!r_vhold) begin
                        n_vhold = 1'b1;
                        n_up    = r_down;
                        n_down  = r_up;
                    end
                    if (!(w_left && w_right)) begin
                        n_hhold = 1'b0;
                        n_left  = w_left;
                        n_right = w_right;
                    end else if (!r_hhold) begin
                        n_hhold = 1'b1;
                        n_left  = r_right;
                        n_right = r_left;
                    end
                end
            end else if (w_is_read && !r_latch && !r_pos[kssr_pkg::POS_W-1]) begin
                n_pos = r_pos + kssr_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= 1'b0;
            r_pos   <= '0;
            r_snap  <= '0;
            r_up    <= 1'b0;
            r_down  <= 1'b0;
            r_left  <= 1'b0;
            r_right <= 1'b0;
            r_vhold <= 1'b0;
            r_hhold <= 1'b0;
        end else begin
            r_latch <= n_latch;
            r_pos   <= n_pos;
            r_snap  <= n_snap;
            r_up    <= n_up;
            r_down  <= n_down;
            r_left  <= n_left;
            r_right <= n_right;
            r_vhold <= n_vhold;
            r_hhold <= n_hhold;
        end
    end

    assign o_result.load       = i_step.fire && w_is_read;
    assign o_result.serial_bit = w_bit;

    `KSSR_ASSERT_NOW(a_pos_bound, i_clk, i_rst_n, 1'b1,
        r_pos <= kssr_pkg::POS_W'(kssr_pkg::SERIAL_LEN))
    `KSSR_ASSERT_NEXT(a_pos_step, i_clk, i_rst_n,
        i_step.fire && w_is_read && !r_latch && !r_pos[kssr_pkg::POS_W-1],
        r_pos == $past(r_pos) + kssr_pkg::POS_W'(1))
    `KSSR_ASSERT_NEXT(a_edge_restart, i_clk, i_rst_n, i_step.fire && w_edge,
        r_pos == '0)
    `KSSR_ASSERT_NOW(a_vhold_snap, i_clk, i_rst_n, r_vhold,
        r_snap[kssr_pkg::BTN_UP] && r_snap[kssr_pkg::BTN_DOWN])
    `KSSR_ASSERT_NOW(a_hhold_snap, i_clk, i_rst_n, r_hhold,
        r_snap[kssr_pkg::BTN_LEFT] && r_snap[kssr_pkg::BTN_RIGHT])

endmodule

`default_nettype wire

### rtl/kssr_out_reg.sv
// ----------------------------------------------------------------------------
// kssr output register
// holds one serial result word until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module kssr_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kssr_pkg::t_result i_result,
    output      logic              o_free,
    kssr_out_if.source             o_out
);

    logic r_valid;
    logic r_bit;
    logic n_valid;

    assign o_free = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_result.load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.load) begin
            r_bit <= i_result.serial_bit;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.serial_bit = r_bit;

endmodule

`default_nettype wire

### rtl/keypad_serial_shift_reader_unit.sv
// path: an accepted read word goes from the input register through the core into
//   the output register, and waits in the input register while that slot is not free
// throughput: one word per cycle while the sink takes each result, set by the single
//   core pass between the input register and the output register
// latch writes give no result word and retire in the cycle after acceptance
// reset (synchronous, active low) clears the latch, bit position, snapshot
//   and direction flags, and empties both registers
// ----------------------------------------------------------------------------
// keypad serial shift reader unit
// serial game-pad keypad port with latch tracking and a 32-bit shift frame
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_serial_shift_reader_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kssr_in_if.sink    i_in,
    kssr_out_if.source o_out
);

    // input register outputs
    logic              w_s1_valid;
    kssr_pkg::t_item   w_s1_item;

    // core handshake
    kssr_pkg::t_step   w_step;
    kssr_pkg::t_result w_result;
    logic              w_out_free;
    logic              w_advance;

    // a latch write never needs the output slot, a read needs it free
    assign w_advance = w_s1_valid &&
                       ((w_s1_item.func == kssr_pkg::FUNC_LATCH) || w_out_free);

    assign w_step.fire = w_advance;
    assign w_step.item = w_s1_item;

    kssr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (w_s1_valid),
        .o_item    (w_s1_item)
    );

    // latch, position, snapshot and direction rule; picks the data bit
    kssr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .o_result (w_result)
    );

    // result word waits here so the input side keeps moving
    kssr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
